// ===== rtl/pbm_pkg.sv =====
`timescale 1ns / 1ps

package pbm_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_MULTIPLY   = 3'd1,
    MODE_SCREEN     = 3'd2,
    MODE_OVERLAY    = 3'd3,
    MODE_DIFFERENCE = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [8:0] opacity;
  } cfg_t;

  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int NUM_STAGES   = 5;

  localparam logic [0:0]  REG_MODE     = 1'b0;
  localparam logic [0:0]  REG_OPACITY  = 1'b1;

  localparam logic [2:0]  MODE_RESET    = 3'd0;
  localparam logic [8:0]  OPACITY_RESET = 9'd256;

  localparam logic [15:0] V_MAX      = 16'd65025;
  localparam logic [7:0]  CH_MAX     = 8'd255;
  localparam logic [18:0] SAT_LIMIT  = 19'd65280;
  localparam logic signed [27:0] HALF_SCALE = 28'sd32640;

endpackage

// ===== rtl/pbm_cfg.sv =====
`timescale 1ns / 1ps

module pbm_cfg
  import pbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] mode_r;
  logic [8:0] opacity_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RESET;
      opacity_r <= OPACITY_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_MODE) begin
        mode_r <= pwdata[2:0];
      end else begin
        opacity_r <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_OPACITY) begin
      prdata = {{(DATA_W-9){1'b0}}, opacity_r};
    end else begin
      prdata = {{(DATA_W-3){1'b0}}, mode_r};
    end
  end

  assign cfg.mode    = mode_r;
  assign cfg.opacity = opacity_r;

`ifndef SYNTHESIS
  a_opacity_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && paddr[2] == REG_OPACITY) |=> (opacity_r == $past(pwdata[8:0])))
    else $error("opacity register not updated by write");
`endif

endmodule

// ===== rtl/pbm_chan.sv =====
`timescale 1ns / 1ps

module pbm_chan
  import pbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NUM_STAGES-1:0] en,
  input  cfg_t                  cfg,
  input  logic [7:0]            a,
  input  logic [7:0]            b,
  output logic [7:0]            y
);

  // stage 1: blend value times 255
  logic [7:0]  ia, ib, absd, mx, my;
  logic [15:0] prod, prod2, v_nxt;
  logic [15:0] v1_r;
  logic [7:0]  a1_r;

  always_comb begin
    ia    = CH_MAX - a;
    ib    = CH_MAX - b;
    absd  = (a > b) ? (a - b) : (b - a);
    case (cfg.mode)
      MODE_MULTIPLY: begin
        mx = a;
        my = b;
      end
      MODE_SCREEN: begin
        mx = ia;
        my = ib;
      end
      MODE_OVERLAY: begin
        mx = a[7] ? ia : a;
        my = a[7] ? ib : b;
      end
      MODE_DIFFERENCE: begin
        mx = absd;
        my = CH_MAX;
      end
      default: begin
        mx = b;
        my = CH_MAX;
      end
    endcase
    prod  = mx * my;
    prod2 = {prod[14:0], 1'b0};
    case (cfg.mode)
      MODE_SCREEN:  v_nxt = V_MAX - prod;
      MODE_OVERLAY: v_nxt = a[7] ? (V_MAX - prod2) : prod2;
      default:      v_nxt = prod;
    endcase
  end

  // stage 2: difference from base
  logic [15:0]        a255;
  logic signed [17:0] d_nxt, d2_r;
  logic [7:0]         a2_r;

  assign a255  = {a1_r, 8'd0} - {8'd0, a1_r};
  assign d_nxt = $signed({2'b00, v1_r}) - $signed({2'b00, a255});

  // stage 3: opacity weight
  logic signed [9:0]  op_s;
  logic signed [27:0] p_nxt, p3_r;
  logic [7:0]         a3_r;

  assign op_s  = $signed({1'b0, cfg.opacity});
  assign p_nxt = d2_r * op_s;

  // stage 4: add base and rounding offset
  logic [27:0]        a_scaled;
  logic signed [27:0] u_nxt, u4_r;

  assign a_scaled = {4'd0, a3_r, 16'd0} - {12'd0, a3_r, 8'd0};
  assign u_nxt    = p3_r + $signed(a_scaled) + HALF_SCALE;

  // stage 5: divide by 65280 and saturate
  logic [18:0] xq;
  logic [15:0] qsum;
  logic [7:0]  y_nxt, y_r;

  always_comb begin
    xq   = u4_r[26:8];
    qsum = xq[15:0] + 16'd1 + {8'd0, xq[15:8]};
    if (u4_r[27]) begin
      y_nxt = 8'd0;
    end else if (xq >= SAT_LIMIT) begin
      y_nxt = CH_MAX;
    end else begin
      y_nxt = qsum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1_r <= v_nxt;
      a1_r <= a;
    end
    if (en[1]) begin
      d2_r <= d_nxt;
      a2_r <= a1_r;
    end
    if (en[2]) begin
      p3_r <= p_nxt;
      a3_r <= a2_r;
    end
    if (en[3]) begin
      u4_r <= u_nxt;
    end
    if (en[4]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

`ifndef SYNTHESIS
  a_neg_mix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en[4] && u4_r[27]) |=> (y_r == 8'd0))
    else $error("negative mix did not give zero");
  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    (en[4] && !u4_r[27] && u4_r[26:8] >= SAT_LIMIT) |=> (y_r == CH_MAX))
    else $error("large mix did not saturate");
`endif

endmodule

// ===== rtl/pixel_blend_modes_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake               word
// in_       in         start / busy            pixel pair a, b (bgr)
// out_      out        out_valid strobe        blended pixel (bgr)
// cfg       in         apb psel/penable/pready blend_mode @0, blend_opacity @4
//
// one word accepted every cycle, result strobed on out_valid at the pipeline end
// each word passes the five-stage channel datapath (blend, diff, weight, add, divide)
// busy is always low, the pipeline never stalls since the receiver cannot
// synchronous active-low reset clears the valid chain and config registers

module pixel_blend_modes_top
  import pbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_a_blue,
  input  logic [7:0]        in_a_green,
  input  logic [7:0]        in_a_red,
  input  logic [7:0]        in_b_blue,
  input  logic [7:0]        in_b_green,
  input  logic [7:0]        in_b_red,
  output logic              out_valid,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_green,
  output logic [7:0]        out_red,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                  cfg;
  logic                  accept;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[NUM_STAGES-2:0], accept};
  assign en      = vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];

  pbm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbm_chan u_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg),
    .a     (in_a_blue),
    .b     (in_b_blue),
    .y     (out_blue)
  );

  pbm_chan u_green (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg),
    .a     (in_a_green),
    .b     (in_b_green),
    .y     (out_green)
  );

  pbm_chan u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg),
    .a     (in_a_red),
    .b     (in_b_red),
    .y     (out_red)
  );

`ifndef SYNTHESIS
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, NUM_STAGES))
    else $error("result strobe without accepted word");
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && vld_r[1]) |=> (vld_r[1] && vld_r[2]))
    else $error("valid chain lost a word");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pbm_pkg::*;

  localparam int     CLK_HALF    = 6;
  localparam int     RESET_CYC   = 9;
  localparam int     PHASES      = 12;
  localparam int     PHASE_WORDS = 150;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint MIX_SCALE   = 65280;
  localparam longint ROUND_HALF  = 32640;

  localparam logic [ADDR_W-1:0] ADDR_MODE    = {REG_MODE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_OPACITY = {REG_OPACITY, 2'b00};

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [7:0]        in_a_blue;
  logic [7:0]        in_a_green;
  logic [7:0]        in_a_red;
  logic [7:0]        in_b_blue;
  logic [7:0]        in_b_green;
  logic [7:0]        in_b_red;
  logic              out_valid;
  logic [7:0]        out_blue;
  logic [7:0]        out_green;
  logic [7:0]        out_red;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [2:0] cur_mode;
  logic [8:0] cur_opacity;
  bgr_t       blended_q[$];
  int         error_count;
  int         cycle_count;
  int         calm_words;

  pixel_blend_modes_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_a_blue  (in_a_blue),
    .in_a_green (in_a_green),
    .in_a_red   (in_a_red),
    .in_b_blue  (in_b_blue),
    .in_b_green (in_b_green),
    .in_b_red   (in_b_red),
    .out_valid  (out_valid),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                               logic [2:0] mode, logic [8:0] op);
    longint av;
    longint bv;
    longint inv_a;
    longint inv_b;
    longint v255;
    longint mix;
    longint rounded;
    av    = longint'(a);
    bv    = longint'(b);
    inv_a = 255 - av;
    inv_b = 255 - bv;
    case (mode)
      MODE_MULTIPLY:   v255 = av * bv;
      MODE_SCREEN:     v255 = 65025 - inv_a * inv_b;
      MODE_OVERLAY:    v255 = (av < 128) ? 2 * av * bv : 65025 - 2 * inv_a * inv_b;
      MODE_DIFFERENCE: v255 = ((av > bv) ? av - bv : bv - av) * 255;
      default:         v255 = bv * 255;
    endcase
    mix = av * 255 * (256 - longint'(op)) + v255 * longint'(op);
    if (mix < 0) return 8'd0;
    rounded = (mix + ROUND_HALF) / MIX_SCALE;
    if (rounded > 255) rounded = 255;
    return rounded[7:0];
  endfunction

  function automatic bgr_t blend_pixel(bgr_t a, bgr_t b);
    bgr_t res;
    res.blue  = blend_channel(a.blue,  b.blue,  cur_mode, cur_opacity);
    res.green = blend_channel(a.green, b.green, cur_mode, cur_opacity);
    res.red   = blend_channel(a.red,   b.red,   cur_mode, cur_opacity);
    return res;
  endfunction

  always @(posedge clk) begin
    bgr_t want;
    if (rst_n && out_valid) begin
      if (blended_q.size() == 0) begin
        $error("unexpected word: blue %0d green %0d red %0d", out_blue, out_green, out_red);
        error_count++;
      end else begin
        want = blended_q.pop_front();
        if (out_blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, out_blue);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, out_green);
          error_count++;
        end
        if (out_red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, out_red);
          error_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (calm_words > 0) begin
      calm_words--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_words = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_pair(bgr_t a, bgr_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_a_blue  = a.blue;
    in_a_green = a.green;
    in_a_red   = a.red;
    in_b_blue  = b.blue;
    in_b_green = b.green;
    in_b_red   = b.red;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    blended_q.push_back(blend_pixel(a, b));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MODE) cur_mode = data[2:0];
    else cur_opacity = data[8:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] want);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata at %0d expected %0d actual %0d", addr, want, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_blend(logic [2:0] mode, logic [8:0] op);
    drain();
    apb_write(ADDR_MODE, DATA_W'(mode));
    apb_write(ADDR_OPACITY, DATA_W'(op));
    apb_check(ADDR_MODE, DATA_W'(mode));
    apb_check(ADDR_OPACITY, DATA_W'(op));
  endtask

  task automatic test_reset_values();
    apb_check(ADDR_MODE, DATA_W'(MODE_RESET));
    apb_check(ADDR_OPACITY, DATA_W'(OPACITY_RESET));
    send_pair('{8'd0, 8'd128, 8'd255}, '{8'd255, 8'd127, 8'd0});
    send_pair('{8'd17, 8'd200, 8'd99}, '{8'd3, 8'd250, 8'd128});
  endtask

  // every mode code at full opacity, including the three unused ones
  task automatic test_each_mode();
    for (int m = 0; m < 8; m++) begin
      set_blend(3'(m), 9'd256);
      send_pair('{8'd0, 8'd127, 8'd255}, '{8'd255, 8'd200, 8'd0});
      send_pair('{8'd128, 8'd255, 8'd0}, '{8'd64, 8'd255, 8'd0});
    end
  endtask

  // zero opacity, just above one and the top of the register
  task automatic test_opacity_extremes();
    set_blend(MODE_OVERLAY, 9'd0);
    send_pair('{8'd0, 8'd128, 8'd255}, '{8'd255, 8'd1, 8'd90});
    set_blend(MODE_DIFFERENCE, 9'd511);
    send_pair('{8'd255, 8'd200, 8'd0}, '{8'd255, 8'd0, 8'd255});
    set_blend(MODE_MULTIPLY, 9'd257);
    send_pair('{8'd255, 8'd128, 8'd10}, '{8'd255, 8'd127, 8'd240});
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 15))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_blends();
    logic [2:0] mode;
    logic [8:0] op;
    bgr_t       a;
    bgr_t       b;
    for (int p = 0; p < PHASES; p++) begin
      mode = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      case ($urandom_range(0, 8))
        0:       op = 9'd0;
        1:       op = 9'd1;
        2:       op = 9'd255;
        3:       op = 9'd256;
        4:       op = 9'd257;
        5:       op = 9'd511;
        6:       op = 9'($urandom_range(0, 511));
        default: op = 9'($urandom_range(0, 256));
      endcase
      set_blend(mode, op);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        a = '{pick_level(), pick_level(), pick_level()};
        b = '{pick_level(), pick_level(), pick_level()};
        send_pair(a, b);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_a_blue   = '0;
    in_a_green  = '0;
    in_a_red    = '0;
    in_b_blue   = '0;
    in_b_green  = '0;
    in_b_red    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cur_mode    = MODE_RESET;
    cur_opacity = OPACITY_RESET;
    error_count = 0;
    cycle_count = 0;
    calm_words  = 0;
    repeat (RESET_CYC) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_each_mode();
    test_opacity_extremes();
    test_random_blends();
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pbm_pkg.sv
rtl/pbm_cfg.sv
rtl/pbm_chan.sv
rtl/pixel_blend_modes_top.sv
sim/tb.sv
